// ----- design/pabs_pkg.sv -----
// Package: shared types, constants and codes of the ping-pong activation bank sequencer.
`timescale 1ns / 1ps

package pabs_pkg;

    localparam int NUM_LANES_DEF = 64;
    localparam int CAPACITY_DEF  = 4096;

    localparam int          IN_SIZE_W  = 13;
    localparam int          CMD_ROW_W  = 16;
    localparam int          QDEPTH     = 2;
    localparam logic [31:0] BIAS_WORD  = 32'h3F80_0000;

    localparam logic [2:0] ACT_FETCH   = 3'd0;
    localparam logic [2:0] ACT_WRITE   = 3'd1;
    localparam logic [2:0] ACT_READ    = 3'd2;
    localparam logic [2:0] ACT_LOAD    = 3'd3;
    localparam logic [2:0] ACT_RESTART = 3'd4;

    localparam logic [1:0] REG_BANK_SELECT = 2'd0;
    localparam logic [1:0] REG_BIAS_ENABLE = 2'd1;
    localparam logic [1:0] REG_INPUT_SIZE  = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [5:0]  lane;
        logic [5:0]  row_addr;
        logic [31:0] data;
    } item_t;

    typedef struct packed {
        logic        source;
        logic [5:0]  out_lane;
        logic [31:0] value;
        logic [6:0]  row_index;
        logic        last;
        logic        layer_done;
    } result_t;

    typedef struct packed {
        logic                 bank_select;
        logic                 bias_enable;
        logic [CMD_ROW_W-1:0] end_row;
    } cfg_t;

    typedef enum logic [2:0] {
        CMD_WRITE = 3'd0,
        CMD_READ  = 3'd1,
        CMD_ROW   = 3'd2,
        CMD_BIAS  = 3'd3,
        CMD_EMPTY = 3'd4
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic                 bank;
        logic [5:0]           lane;
        logic [CMD_ROW_W-1:0] row;
        logic [31:0]          data;
        logic [6:0]           row_index;
        logic                 done;
        logic                 in_bank;
    } cmd_t;

endpackage

// ----- design/pabs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pabs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/pabs_queue.sv -----
// Short command queue between the front and back parts.
`timescale 1ns / 1ps

module pabs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pabs_pkg::cmd_t push_cmd,
    input  logic           pop,
    output pabs_pkg::cmd_t head,
    output logic           full,
    output logic           empty
);

    localparam int PTR_W = (pabs_pkg::QDEPTH > 1) ? $clog2(pabs_pkg::QDEPTH) : 1;
    localparam int CNT_W = $clog2(pabs_pkg::QDEPTH + 1);

    pabs_pkg::cmd_t   slot_reg [pabs_pkg::QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(pabs_pkg::QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(pabs_pkg::QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(pabs_pkg::QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- design/pabs_front.sv -----
// Front part: accepts items, runs the fetch sequencer and issues bank commands.
`timescale 1ns / 1ps

module pabs_front #(
    parameter int NUM_LANES = pabs_pkg::NUM_LANES_DEF,
    parameter int CAPACITY  = pabs_pkg::CAPACITY_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  pabs_pkg::item_t item,
    input  logic            item_valid,
    output logic            item_ready,
    input  pabs_pkg::cfg_t  cfg,
    input  logic            clearing,
    input  logic            q_full,
    output logic            push,
    output pabs_pkg::cmd_t  cmd
);

    localparam int BANK_ROWS = (CAPACITY - 1) / NUM_LANES + 1;
    localparam int PTR_W     = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1;
    localparam int RW        = pabs_pkg::CMD_ROW_W;

    typedef enum logic [2:0] {
        PH_ACT   = 3'b001,
        PH_BIAS  = 3'b010,
        PH_EMPTY = 3'b100
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;

    logic          take;
    logic          in_bank;
    logic [RW-1:0] ptr_ext;
    logic [RW-1:0] end_plus;
    logic          at_end;

    assign item_ready = !clearing && !q_full;
    assign take       = item_valid && item_ready;
    assign in_bank    = ({1'b0, item.lane} < 7'(NUM_LANES))
                     && (17'(item.row_addr) < 17'(BANK_ROWS));
    assign ptr_ext    = RW'(ptr_reg);
    assign end_plus   = cfg.end_row + 1'b1;
    assign at_end     = (ptr_ext >= cfg.end_row);

    always_comb
    begin
        cmd.kind      = pabs_pkg::CMD_WRITE;
        cmd.bank      = cfg.bank_select;
        cmd.lane      = item.lane;
        cmd.row       = RW'(item.row_addr);
        cmd.data      = item.data;
        cmd.row_index = '0;
        cmd.done      = (phase_reg == PH_EMPTY);
        cmd.in_bank   = in_bank;
        push          = 1'b0;
        ptr_next      = ptr_reg;
        phase_next    = phase_reg;
        case (item.action)
            pabs_pkg::ACT_FETCH:
            begin
                push = take;
                case (phase_reg)
                    PH_ACT:
                    begin
                        cmd.kind      = pabs_pkg::CMD_ROW;
                        cmd.row       = ptr_ext;
                        cmd.row_index = ptr_ext[6:0];
                        if (take)
                        begin
                            if (at_end)
                            begin
                                ptr_next   = '0;
                                phase_next = cfg.bias_enable ? PH_BIAS : PH_EMPTY;
                            end
                            else
                            begin
                                ptr_next = ptr_reg + 1'b1;
                            end
                        end
                    end
                    PH_BIAS:
                    begin
                        cmd.kind      = pabs_pkg::CMD_BIAS;
                        cmd.row_index = end_plus[6:0];
                        if (take)
                        begin
                            ptr_next   = '0;
                            phase_next = PH_EMPTY;
                        end
                    end
                    default:
                    begin
                        cmd.kind = pabs_pkg::CMD_EMPTY;
                        if (take)
                        begin
                            ptr_next   = '0;
                            phase_next = PH_EMPTY;
                        end
                    end
                endcase
            end
            pabs_pkg::ACT_WRITE:
            begin
                push     = take && in_bank;
                cmd.bank = !cfg.bank_select;
            end
            pabs_pkg::ACT_LOAD:
            begin
                push = take && in_bank;
            end
            pabs_pkg::ACT_READ:
            begin
                push     = take;
                cmd.kind = pabs_pkg::CMD_READ;
                cmd.bank = !cfg.bank_select;
            end
            pabs_pkg::ACT_RESTART:
            begin
                if (take)
                begin
                    ptr_next   = '0;
                    phase_next = PH_ACT;
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ACT;
            ptr_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            ptr_reg   <= ptr_next;
        end
    end

endmodule

// ----- design/pabs_back.sv -----
// Back part: lane-banked memories, clearing pass, row drain and output register.
`timescale 1ns / 1ps

module pabs_back #(
    parameter int NUM_LANES = pabs_pkg::NUM_LANES_DEF,
    parameter int CAPACITY  = pabs_pkg::CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pabs_pkg::cmd_t    head,
    input  logic              q_empty,
    output logic              pop,
    output logic              clearing,
    output pabs_pkg::result_t result,
    output logic              result_valid,
    input  logic              result_ready
);

    localparam int BANK_ROWS = (CAPACITY - 1) / NUM_LANES + 1;
    localparam int RAM_DEPTH = 2 * BANK_ROWS;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam int LANE_IW   = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;

    typedef enum logic [2:0] {
        BK_CLEAR = 3'b001,
        BK_IDLE  = 3'b010,
        BK_DRAIN = 3'b100
    } bk_state_t;

    bk_state_t          state_reg, state_next;
    logic [RAM_AW-1:0]  clr_reg, clr_next;
    logic [LANE_IW-1:0] lcnt_reg, lcnt_next;
    pabs_pkg::cmd_t     cur_reg, cur_next;
    pabs_pkg::result_t  res_reg, res_next;
    logic               res_valid_reg, res_valid_next;

    logic [RAM_AW-1:0]    head_addr;
    logic [RAM_AW-1:0]    waddr;
    logic                 wr_now;
    logic                 rd_en;
    logic [NUM_LANES-1:0] lane_we;
    logic [31:0]          rd_data [NUM_LANES];
    logic [31:0]          elem_value;
    logic                 elem_last;
    logic                 out_free;

    assign clearing  = (state_reg == BK_CLEAR);
    assign head_addr = RAM_AW'(head.row) + (head.bank ? RAM_AW'(BANK_ROWS) : '0);
    assign waddr     = clearing ? clr_reg : head_addr;
    assign out_free  = !res_valid_reg || result_ready;

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            lane_we[i] = clearing || (wr_now && (head.lane == 6'(i)));
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        pabs_ram #(
            .WIDTH(32),
            .DEPTH(RAM_DEPTH)
        ) u_ram (
            .clk  (clk),
            .we   (lane_we[g]),
            .waddr(waddr),
            .wdata(clearing ? 32'd0 : head.data),
            .re   (rd_en),
            .raddr(head_addr),
            .rdata(rd_data[g])
        );
    end

    always_comb
    begin
        case (cur_reg.kind)
            pabs_pkg::CMD_ROW:  elem_value = rd_data[lcnt_reg];
            pabs_pkg::CMD_BIAS: elem_value = (lcnt_reg == '0) ? pabs_pkg::BIAS_WORD : 32'd0;
            pabs_pkg::CMD_READ: elem_value = cur_reg.in_bank
                                           ? rd_data[cur_reg.lane[LANE_IW-1:0]] : 32'd0;
            default:            elem_value = 32'd0;
        endcase
        elem_last = (cur_reg.kind == pabs_pkg::CMD_READ)
                 || (lcnt_reg == LANE_IW'(NUM_LANES - 1));
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        lcnt_next      = lcnt_reg;
        cur_next       = cur_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !result_ready;
        pop            = 1'b0;
        wr_now         = 1'b0;
        rd_en          = 1'b0;
        case (state_reg)
            BK_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == RAM_AW'(RAM_DEPTH - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop       = 1'b1;
                    cur_next  = head;
                    lcnt_next = '0;
                    case (head.kind)
                        pabs_pkg::CMD_WRITE:
                        begin
                            wr_now = 1'b1;
                        end
                        pabs_pkg::CMD_READ, pabs_pkg::CMD_ROW:
                        begin
                            rd_en      = 1'b1;
                            state_next = BK_DRAIN;
                        end
                        default:
                        begin
                            state_next = BK_DRAIN;
                        end
                    endcase
                end
            end
            BK_DRAIN:
            begin
                if (out_free)
                begin
                    res_valid_next     = 1'b1;
                    res_next.source    = (cur_reg.kind == pabs_pkg::CMD_READ);
                    res_next.out_lane  = (cur_reg.kind == pabs_pkg::CMD_READ)
                                       ? cur_reg.lane : 6'(lcnt_reg);
                    res_next.value     = elem_value;
                    res_next.row_index = cur_reg.row_index;
                    res_next.last      = elem_last;
                    res_next.layer_done = cur_reg.done;
                    lcnt_next          = lcnt_reg + 1'b1;
                    if (elem_last)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_reg       <= '0;
            lcnt_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            lcnt_reg      <= lcnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_reg <= res_next;
    end

    assign result       = res_reg;
    assign result_valid = res_valid_reg;

endmodule

// ----- design/pingpong_activation_bank_sequencer_unit.sv -----
// Top level: configuration registers and the front, queue and back parts of the sequencer.
//
//   channel  direction  handshake                      payload
//   item     in         item_valid / item_ready        pabs_pkg::item_t
//   result   out        result_valid / result_ready    pabs_pkg::result_t
//   config   in         APB psel/penable/pwrite        paddr[3:2] selects register
//
// Lane write: done as the back part pops the command. Lane read: a row read, then output.
// Fetch step: a parallel row read, then one lane per cycle through the output register
// while the result is not stalled. After reset a clearing pass over all 2*BANK_ROWS
// addresses (128 at default sizes) zeroes both banks; item_ready stays low meanwhile.
// A stalled result holds the drain; the two-entry queue lets the front accept until full.
`timescale 1ns / 1ps

module pingpong_activation_bank_sequencer_unit #(
    parameter int NUM_LANES = pabs_pkg::NUM_LANES_DEF,
    parameter int CAPACITY  = pabs_pkg::CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pabs_pkg::item_t   item,
    input  logic              item_valid,
    output logic              item_ready,
    output pabs_pkg::result_t result,
    output logic              result_valid,
    input  logic              result_ready,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int          ISW       = pabs_pkg::IN_SIZE_W;
    localparam int          RW        = pabs_pkg::CMD_ROW_W;
    localparam int          DIV_SHIFT = ISW + ((NUM_LANES > 1) ? $clog2(NUM_LANES) : 0);
    localparam logic [31:0] DIV_MUL   = 32'(((64'd1 << DIV_SHIFT) + NUM_LANES - 1) / NUM_LANES);

    logic           bank_select_reg;
    logic           bias_enable_reg;
    logic [ISW-1:0] input_size_reg;
    logic [RW-1:0]  end_row_reg, end_row_next;

    logic           wr_en;
    logic [ISW-1:0] size_raw;
    logic [ISW-1:0] size_sat;
    logic [ISW-1:0] size_m1;
    logic [44:0]    end_prod;

    pabs_pkg::cfg_t cfg;
    pabs_pkg::cmd_t push_cmd;
    pabs_pkg::cmd_t head;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;
    logic           clearing;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite && pready;
    assign size_raw = pwdata[ISW-1:0];

    // end row = (saturated size - 1) / NUM_LANES by reciprocal multiply
    always_comb
    begin
        if (size_raw == '0)
        begin
            size_sat = ISW'(1);
        end
        else if (17'(size_raw) > 17'(CAPACITY))
        begin
            size_sat = ISW'(CAPACITY);
        end
        else
        begin
            size_sat = size_raw;
        end
        size_m1      = size_sat - 1'b1;
        end_prod     = 45'(size_m1) * 45'(DIV_MUL);
        end_row_next = RW'(end_prod >> DIV_SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_select_reg <= 1'b0;
            bias_enable_reg <= 1'b0;
            input_size_reg  <= ISW'(1);
            end_row_reg     <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                pabs_pkg::REG_BANK_SELECT: bank_select_reg <= pwdata[0];
                pabs_pkg::REG_BIAS_ENABLE: bias_enable_reg <= pwdata[0];
                pabs_pkg::REG_INPUT_SIZE:
                begin
                    input_size_reg <= size_raw;
                    end_row_reg    <= end_row_next;
                end
                default:
                begin
                    bank_select_reg <= bank_select_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            pabs_pkg::REG_BANK_SELECT: prdata = {31'd0, bank_select_reg};
            pabs_pkg::REG_BIAS_ENABLE: prdata = {31'd0, bias_enable_reg};
            pabs_pkg::REG_INPUT_SIZE:  prdata = 32'(input_size_reg);
            default:                   prdata = 32'd0;
        endcase
    end

    assign cfg.bank_select = bank_select_reg;
    assign cfg.bias_enable = bias_enable_reg;
    assign cfg.end_row     = end_row_reg;

    pabs_front #(
        .NUM_LANES(NUM_LANES),
        .CAPACITY (CAPACITY)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .cfg       (cfg),
        .clearing  (clearing),
        .q_full    (q_full),
        .push      (push),
        .cmd       (push_cmd)
    );

    pabs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_cmd(push_cmd),
        .pop     (pop),
        .head    (head),
        .full    (q_full),
        .empty   (q_empty)
    );

    pabs_back #(
        .NUM_LANES(NUM_LANES),
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_empty     (q_empty),
        .pop         (pop),
        .clearing    (clearing),
        .result      (result),
        .result_valid(result_valid),
        .result_ready(result_ready)
    );

endmodule
